### hw/rtl/mpmc_pkg.sv
// Shared types, constants and helper functions for the multi-pattern match counter.
// Used by mpmc_ctrl, mpmc_datapath and multi_pattern_match_counter; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mpmc_pkg;

    localparam int ALPHABET  = 26;
    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int IDX_W     = $clog2(ALPHABET);
    localparam int SYM_W     = 5;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 2;
    localparam int COUNT_W   = 16;
    localparam int TOTAL_W   = 32;
    localparam int GT_DEPTH  = MAX_NODES * ALPHABET;
    localparam int GT_AW     = $clog2(GT_DEPTH);
    localparam int IN_W      = 8;
    localparam int OUT_W     = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PATTERN = 2'd0,
        FUNC_BUILD   = 2'd1,
        FUNC_TEXT    = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_PHASE = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR_STEP,
        OP_CLEAR_END,
        OP_PHASE_ERR,
        OP_PAT_RD,
        OP_PAT_EV,
        OP_PAT_CNT,
        OP_ROOT_RD,
        OP_ROOT_EV,
        OP_Q_RD,
        OP_Q_U,
        OP_L_U,
        OP_SYM_RD,
        OP_SYM_EV,
        OP_SYM_MC,
        OP_BUILD_END,
        OP_TEXT_RD,
        OP_TEXT_MC,
        OP_TEXT_END,
        OP_LOAD_OUT
    } op_t;

    typedef struct packed {
        logic take;
        op_t  op;
    } ctl_t;

    typedef struct packed {
        func_t in_func;
        logic  in_sym_ok;
        logic  built;
        logic  present;
        logic  i_end;
        logic  q_empty;
        logic  clr_end;
        logic  out_free;
    } stat_t;

    function automatic logic [GT_AW-1:0] gt_index(input logic [NODE_W-1:0] node,
                                                  input logic [IDX_W-1:0] sym);
        return GT_AW'(node) * GT_AW'(ALPHABET) + GT_AW'(sym);
    endfunction

    function automatic logic [COUNT_W-1:0] sat16(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] sat32(input logic [TOTAL_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W + 1)'(b);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/mpmc_ctrl.sv
// Sequencing state machine of the multi-pattern match counter.
// Depends on mpmc_pkg; drives the datapath through mpmc_pkg::ctl_t commands.
`timescale 1ns / 1ps
`default_nettype none
module mpmc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mpmc_pkg::stat_t stat,
    output mpmc_pkg::ctl_t  ctl
);

    typedef enum logic [4:0] {
        S_RST_CLR,
        S_IDLE,
        S_CLR,
        S_CLR_END,
        S_PHASE,
        S_PAT_RD,
        S_PAT_EV,
        S_PAT_CNT,
        S_ROOT_RD,
        S_ROOT_EV,
        S_Q_CHK,
        S_Q_RD,
        S_Q_U,
        S_L_U,
        S_SYM_RD,
        S_SYM_EV,
        S_SYM_MC,
        S_BUILD_END,
        S_TEXT_RD,
        S_TEXT_MC,
        S_TEXT_END,
        S_RES
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl.take   = 1'b0;
        ctl.op     = mpmc_pkg::OP_NONE;
        case (state_reg)
            S_RST_CLR:
            begin
                ctl.op = mpmc_pkg::OP_CLEAR_STEP;
                if (stat.clr_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.take = 1'b1;
                    case (stat.in_func)
                        mpmc_pkg::FUNC_PATTERN:
                        begin
                            state_next = (stat.built || !stat.in_sym_ok) ? S_PHASE : S_PAT_RD;
                        end
                        mpmc_pkg::FUNC_BUILD:
                        begin
                            state_next = stat.built ? S_PHASE : S_ROOT_RD;
                        end
                        mpmc_pkg::FUNC_TEXT:
                        begin
                            state_next = stat.built ? S_TEXT_RD : S_PHASE;
                        end
                        default:
                        begin
                            state_next = S_CLR;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                ctl.op = mpmc_pkg::OP_CLEAR_STEP;
                if (stat.clr_end)
                begin
                    state_next = S_CLR_END;
                end
            end
            S_CLR_END:
            begin
                ctl.op     = mpmc_pkg::OP_CLEAR_END;
                state_next = S_RES;
            end
            S_PHASE:
            begin
                ctl.op     = mpmc_pkg::OP_PHASE_ERR;
                state_next = S_RES;
            end
            S_PAT_RD:
            begin
                ctl.op     = mpmc_pkg::OP_PAT_RD;
                state_next = S_PAT_EV;
            end
            S_PAT_EV:
            begin
                ctl.op     = mpmc_pkg::OP_PAT_EV;
                state_next = S_PAT_CNT;
            end
            S_PAT_CNT:
            begin
                ctl.op     = mpmc_pkg::OP_PAT_CNT;
                state_next = S_RES;
            end
            S_ROOT_RD:
            begin
                ctl.op     = mpmc_pkg::OP_ROOT_RD;
                state_next = S_ROOT_EV;
            end
            S_ROOT_EV:
            begin
                ctl.op     = mpmc_pkg::OP_ROOT_EV;
                state_next = stat.i_end ? S_Q_CHK : S_ROOT_RD;
            end
            S_Q_CHK:
            begin
                state_next = stat.q_empty ? S_BUILD_END : S_Q_RD;
            end
            S_Q_RD:
            begin
                ctl.op     = mpmc_pkg::OP_Q_RD;
                state_next = S_Q_U;
            end
            S_Q_U:
            begin
                ctl.op     = mpmc_pkg::OP_Q_U;
                state_next = S_L_U;
            end
            S_L_U:
            begin
                ctl.op     = mpmc_pkg::OP_L_U;
                state_next = S_SYM_RD;
            end
            S_SYM_RD:
            begin
                ctl.op     = mpmc_pkg::OP_SYM_RD;
                state_next = S_SYM_EV;
            end
            S_SYM_EV:
            begin
                ctl.op = mpmc_pkg::OP_SYM_EV;
                if (stat.present)
                begin
                    state_next = S_SYM_MC;
                end
                else
                begin
                    state_next = stat.i_end ? S_Q_CHK : S_SYM_RD;
                end
            end
            S_SYM_MC:
            begin
                ctl.op     = mpmc_pkg::OP_SYM_MC;
                state_next = stat.i_end ? S_Q_CHK : S_SYM_RD;
            end
            S_BUILD_END:
            begin
                ctl.op     = mpmc_pkg::OP_BUILD_END;
                state_next = S_RES;
            end
            S_TEXT_RD:
            begin
                ctl.op     = mpmc_pkg::OP_TEXT_RD;
                state_next = S_TEXT_MC;
            end
            S_TEXT_MC:
            begin
                ctl.op     = mpmc_pkg::OP_TEXT_MC;
                state_next = S_TEXT_END;
            end
            S_TEXT_END:
            begin
                ctl.op     = mpmc_pkg::OP_TEXT_END;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (stat.out_free)
                begin
                    ctl.op     = mpmc_pkg::OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/mpmc_datapath.sv
// Datapath of the multi-pattern match counter: goto table, suffix links, match counts,
// breadth-first queue, automaton registers and the output register. Depends on mpmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpmc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mpmc_pkg::ctl_t                ctl,
    input  logic [mpmc_pkg::IN_W-1:0]     s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [mpmc_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tlast,
    output mpmc_pkg::stat_t               stat
);

    localparam int NW = mpmc_pkg::NODE_W;
    localparam int CW = mpmc_pkg::COUNT_W;
    localparam int TW = mpmc_pkg::TOTAL_W;
    localparam int AW = mpmc_pkg::GT_AW;
    localparam int IW = mpmc_pkg::IDX_W;

    logic [NW:0]   gt_mem [mpmc_pkg::GT_DEPTH];
    logic [CW-1:0] mc_mem [mpmc_pkg::MAX_NODES];
    logic [NW-1:0] sl_mem [mpmc_pkg::MAX_NODES];
    logic [NW-1:0] q_mem  [mpmc_pkg::MAX_NODES];

    logic [NW:0]   gt_qa, gt_qb, gt_wd;
    logic [AW-1:0] gt_ra, gt_rb, gt_wa;
    logic          gt_we;
    logic [CW-1:0] mc_qa, mc_qb, mc_wd;
    logic [NW-1:0] mc_ra, mc_rb, mc_wa;
    logic          mc_we;
    logic [NW-1:0] sl_q, sl_ra, sl_wa, sl_wd;
    logic          sl_we;
    logic [NW-1:0] q_q, q_ra, q_wa, q_wd;
    logic          q_we;

    mpmc_pkg::func_t   func_reg;
    logic [mpmc_pkg::SYM_W-1:0] sym_reg;
    logic              last_reg;
    logic [NW:0]       nodes_used_reg;
    logic [NW-1:0]     cursor_reg;
    logic              dropped_reg;
    logic              built_reg;
    logic [NW-1:0]     tn_reg;
    logic [TW-1:0]     total_reg;
    logic [NW:0]       head_reg, tail_reg;
    logic [IW-1:0]     i_reg;
    logic [NW-1:0]     u_reg, lu_reg, v_reg;
    logic              cnt_en_reg;
    logic [AW-1:0]     sw_reg;
    mpmc_pkg::status_t res_status_reg;
    logic [CW-1:0]     res_here_reg;
    logic [TW-1:0]     res_total_reg;
    logic [NW-1:0]     res_node_reg;
    logic              out_valid_reg;
    mpmc_pkg::status_t out_status_reg;
    logic [CW-1:0]     out_here_reg;
    logic [TW-1:0]     out_total_reg;
    logic [NW-1:0]     out_node_reg;
    logic              out_last_reg;

    logic          sym_ok;
    logic [IW-1:0] sym_eff;
    logic          present;
    logic [NW-1:0] e_node, via;
    logic          full, q_room;
    logic          pat_drop_n;
    logic [NW-1:0] pat_cur_n;
    logic [NW-1:0] text_nxt;
    logic [TW-1:0] total_n;

    assign sym_ok   = sym_reg < mpmc_pkg::SYM_W'(mpmc_pkg::ALPHABET);
    assign sym_eff  = sym_ok ? sym_reg[IW-1:0] : '0;
    assign present  = gt_qa[NW];
    assign e_node   = gt_qa[NW-1:0];
    assign via      = gt_qb[NW-1:0];
    assign full     = nodes_used_reg >= (NW + 1)'(mpmc_pkg::MAX_NODES);
    assign q_room   = tail_reg < (NW + 1)'(mpmc_pkg::MAX_NODES);
    assign text_nxt = sym_ok ? e_node : '0;
    assign total_n  = mpmc_pkg::sat32(total_reg, mc_qa);

    always_comb
    begin
        pat_drop_n = dropped_reg;
        pat_cur_n  = cursor_reg;
        if (!dropped_reg)
        begin
            if (present)
            begin
                pat_cur_n = e_node;
            end
            else if (full)
            begin
                pat_drop_n = 1'b1;
            end
            else
            begin
                pat_cur_n = nodes_used_reg[NW-1:0];
            end
        end
    end

    always_comb
    begin
        gt_ra = '0;
        gt_rb = '0;
        gt_we = 1'b0;
        gt_wa = '0;
        gt_wd = '0;
        mc_ra = '0;
        mc_rb = '0;
        mc_we = 1'b0;
        mc_wa = '0;
        mc_wd = '0;
        sl_ra = '0;
        sl_we = 1'b0;
        sl_wa = '0;
        sl_wd = '0;
        q_ra  = '0;
        q_we  = 1'b0;
        q_wa  = '0;
        q_wd  = '0;
        case (ctl.op)
            mpmc_pkg::OP_CLEAR_STEP:
            begin
                gt_we = 1'b1;
                gt_wa = sw_reg;
                mc_we = sw_reg < AW'(mpmc_pkg::MAX_NODES);
                mc_wa = sw_reg[NW-1:0];
            end
            mpmc_pkg::OP_PAT_RD:
            begin
                gt_ra = mpmc_pkg::gt_index(cursor_reg, sym_eff);
            end
            mpmc_pkg::OP_PAT_EV:
            begin
                gt_we = !dropped_reg && !present && !full;
                gt_wa = mpmc_pkg::gt_index(cursor_reg, sym_eff);
                gt_wd = {1'b1, nodes_used_reg[NW-1:0]};
                mc_ra = pat_cur_n;
            end
            mpmc_pkg::OP_PAT_CNT:
            begin
                mc_we = cnt_en_reg;
                mc_wa = cursor_reg;
                mc_wd = mpmc_pkg::sat16(mc_qa, CW'(1));
            end
            mpmc_pkg::OP_ROOT_RD:
            begin
                gt_ra = AW'(i_reg);
            end
            mpmc_pkg::OP_ROOT_EV:
            begin
                if (present)
                begin
                    sl_we = 1'b1;
                    sl_wa = e_node;
                    q_we  = q_room;
                    q_wa  = tail_reg[NW-1:0];
                    q_wd  = e_node;
                end
                else
                begin
                    gt_we = 1'b1;
                    gt_wa = AW'(i_reg);
                    gt_wd = {1'b1, {NW{1'b0}}};
                end
            end
            mpmc_pkg::OP_Q_RD:
            begin
                q_ra = head_reg[NW-1:0];
            end
            mpmc_pkg::OP_Q_U:
            begin
                sl_ra = q_q;
            end
            mpmc_pkg::OP_SYM_RD:
            begin
                gt_ra = mpmc_pkg::gt_index(u_reg, i_reg);
                gt_rb = mpmc_pkg::gt_index(lu_reg, i_reg);
            end
            mpmc_pkg::OP_SYM_EV:
            begin
                if (present)
                begin
                    sl_we = 1'b1;
                    sl_wa = e_node;
                    sl_wd = via;
                    q_we  = q_room;
                    q_wa  = tail_reg[NW-1:0];
                    q_wd  = e_node;
                    mc_ra = e_node;
                    mc_rb = via;
                end
                else
                begin
                    gt_we = 1'b1;
                    gt_wa = mpmc_pkg::gt_index(u_reg, i_reg);
                    gt_wd = {1'b1, via};
                end
            end
            mpmc_pkg::OP_SYM_MC:
            begin
                mc_we = 1'b1;
                mc_wa = v_reg;
                mc_wd = mpmc_pkg::sat16(mc_qa, mc_qb);
            end
            mpmc_pkg::OP_TEXT_RD:
            begin
                gt_ra = mpmc_pkg::gt_index(tn_reg, sym_eff);
            end
            mpmc_pkg::OP_TEXT_MC:
            begin
                mc_ra = text_nxt;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (gt_we)
        begin
            gt_mem[gt_wa] <= gt_wd;
        end
        gt_qa <= gt_mem[gt_ra];
        gt_qb <= gt_mem[gt_rb];
    end

    always_ff @(posedge clk)
    begin
        if (mc_we)
        begin
            mc_mem[mc_wa] <= mc_wd;
        end
        mc_qa <= mc_mem[mc_ra];
        mc_qb <= mc_mem[mc_rb];
    end

    always_ff @(posedge clk)
    begin
        if (sl_we)
        begin
            sl_mem[sl_wa] <= sl_wd;
        end
        sl_q <= sl_mem[sl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        q_q <= q_mem[q_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg       <= mpmc_pkg::FUNC_PATTERN;
            sym_reg        <= '0;
            last_reg       <= 1'b0;
            nodes_used_reg <= (NW + 1)'(1);
            cursor_reg     <= '0;
            dropped_reg    <= 1'b0;
            built_reg      <= 1'b0;
            tn_reg         <= '0;
            total_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            i_reg          <= '0;
            u_reg          <= '0;
            lu_reg         <= '0;
            v_reg          <= '0;
            cnt_en_reg     <= 1'b0;
            sw_reg         <= '0;
            res_status_reg <= mpmc_pkg::ST_OK;
            res_here_reg   <= '0;
            res_total_reg  <= '0;
            res_node_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= mpmc_pkg::ST_OK;
            out_here_reg   <= '0;
            out_total_reg  <= '0;
            out_node_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && (ctl.op != mpmc_pkg::OP_LOAD_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.take)
            begin
                func_reg <= mpmc_pkg::func_t'(s_tdata[mpmc_pkg::FUNC_W-1:0]);
                sym_reg  <= s_tdata[mpmc_pkg::FUNC_W +: mpmc_pkg::SYM_W];
                last_reg <= s_tlast;
                i_reg    <= '0;
                head_reg <= '0;
                tail_reg <= '0;
                sw_reg   <= '0;
            end
            case (ctl.op)
                mpmc_pkg::OP_CLEAR_STEP:
                begin
                    sw_reg <= sw_reg + AW'(1);
                end
                mpmc_pkg::OP_CLEAR_END:
                begin
                    nodes_used_reg <= (NW + 1)'(1);
                    cursor_reg     <= '0;
                    dropped_reg    <= 1'b0;
                    built_reg      <= 1'b0;
                    tn_reg         <= '0;
                    total_reg      <= '0;
                    res_status_reg <= mpmc_pkg::ST_OK;
                    res_here_reg   <= '0;
                    res_total_reg  <= '0;
                    res_node_reg   <= '0;
                end
                mpmc_pkg::OP_PHASE_ERR:
                begin
                    res_status_reg <= mpmc_pkg::ST_PHASE;
                    res_here_reg   <= '0;
                    res_total_reg  <= '0;
                    if (func_reg == mpmc_pkg::FUNC_PATTERN)
                    begin
                        res_node_reg <= cursor_reg;
                    end
                    else if (func_reg == mpmc_pkg::FUNC_TEXT)
                    begin
                        res_node_reg <= tn_reg;
                    end
                    else
                    begin
                        res_node_reg <= '0;
                    end
                end
                mpmc_pkg::OP_PAT_EV:
                begin
                    cursor_reg  <= pat_cur_n;
                    dropped_reg <= pat_drop_n;
                    if (!dropped_reg && !present && !full)
                    begin
                        nodes_used_reg <= nodes_used_reg + (NW + 1)'(1);
                    end
                    cnt_en_reg <= last_reg && !pat_drop_n;
                end
                mpmc_pkg::OP_PAT_CNT:
                begin
                    res_status_reg <= dropped_reg ? mpmc_pkg::ST_FULL : mpmc_pkg::ST_OK;
                    res_here_reg   <= '0;
                    res_total_reg  <= '0;
                    res_node_reg   <= last_reg ? '0 : cursor_reg;
                    if (last_reg)
                    begin
                        cursor_reg  <= '0;
                        dropped_reg <= 1'b0;
                    end
                end
                mpmc_pkg::OP_ROOT_EV:
                begin
                    if (present && q_room)
                    begin
                        tail_reg <= tail_reg + (NW + 1)'(1);
                    end
                    i_reg <= i_reg + IW'(1);
                end
                mpmc_pkg::OP_Q_U:
                begin
                    u_reg    <= q_q;
                    head_reg <= head_reg + (NW + 1)'(1);
                end
                mpmc_pkg::OP_L_U:
                begin
                    lu_reg <= sl_q;
                    i_reg  <= '0;
                end
                mpmc_pkg::OP_SYM_EV:
                begin
                    if (present)
                    begin
                        v_reg <= e_node;
                        if (q_room)
                        begin
                            tail_reg <= tail_reg + (NW + 1)'(1);
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + IW'(1);
                    end
                end
                mpmc_pkg::OP_SYM_MC:
                begin
                    i_reg <= i_reg + IW'(1);
                end
                mpmc_pkg::OP_BUILD_END:
                begin
                    built_reg      <= 1'b1;
                    cursor_reg     <= '0;
                    dropped_reg    <= 1'b0;
                    res_status_reg <= mpmc_pkg::ST_OK;
                    res_here_reg   <= '0;
                    res_total_reg  <= '0;
                    res_node_reg   <= '0;
                end
                mpmc_pkg::OP_TEXT_MC:
                begin
                    tn_reg <= text_nxt;
                end
                mpmc_pkg::OP_TEXT_END:
                begin
                    res_status_reg <= mpmc_pkg::ST_OK;
                    res_here_reg   <= mc_qa;
                    res_total_reg  <= total_n;
                    res_node_reg   <= tn_reg;
                    if (last_reg)
                    begin
                        tn_reg    <= '0;
                        total_reg <= '0;
                    end
                    else
                    begin
                        total_reg <= total_n;
                    end
                end
                mpmc_pkg::OP_LOAD_OUT:
                begin
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= res_status_reg;
                    out_here_reg   <= res_here_reg;
                    out_total_reg  <= res_total_reg;
                    out_node_reg   <= res_node_reg;
                    out_last_reg   <= last_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = mpmc_pkg::OUT_W'({out_node_reg, out_total_reg, out_here_reg,
                                        out_status_reg});

    assign stat.in_func   = mpmc_pkg::func_t'(s_tdata[mpmc_pkg::FUNC_W-1:0]);
    assign stat.in_sym_ok = s_tdata[mpmc_pkg::FUNC_W +: mpmc_pkg::SYM_W]
                            < mpmc_pkg::SYM_W'(mpmc_pkg::ALPHABET);
    assign stat.built     = built_reg;
    assign stat.present   = present;
    assign stat.i_end     = i_reg == IW'(mpmc_pkg::ALPHABET - 1);
    assign stat.q_empty   = head_reg == tail_reg;
    assign stat.clr_end   = sw_reg == AW'(mpmc_pkg::GT_DEPTH - 1);
    assign stat.out_free  = !out_valid_reg || m_tready;

endmodule
`default_nettype wire

### hw/rtl/multi_pattern_match_counter.sv
// Top level of the multi-pattern match counter (Aho-Corasick automaton, 26 letters).
// Depends on mpmc_pkg, mpmc_ctrl and mpmc_datapath.
//
// Input beats on s_* carry a function code, a letter and tlast; every beat yields exactly
// one output beat on m_* with status, matches at this symbol, running total and node.
// Pattern beats (function 0) grow the trie, tlast closes a pattern. A build beat
// (function 1) runs the breadth-first link pass. Text beats (function 2) step the
// automaton; tlast ends the text and returns to the root. Function 3 clears everything.
// One beat is worked at a time. A pattern or text beat makes a registered read of the goto
// table and then one of the match count memory before its result is formed; a wrong-phase
// beat goes straight to its result. A build beat visits the root's children, then takes
// each trie node in breadth-first order through all 26 letters. A clear beat sweeps the
// goto table and match counts. After reset the block sweeps them too, with s_tready low.
// The result waits in an output register; while m_tready is low the next
// beat is still accepted and worked, and only its result waits for the register.
`timescale 1ns / 1ps
`default_nettype none
module multi_pattern_match_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] func, [6:2] symbol, [7] zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [1:0] status, [17:2] matches_here,
                                   // [49:18] running_total, [59:50] node_now, [63:60] zero
    output logic        m_tlast
);

    mpmc_pkg::ctl_t  ctl;
    mpmc_pkg::stat_t stat;

    mpmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    mpmc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == mpmc_pkg::ST_OK || m_tdata[1:0] == mpmc_pkg::ST_FULL
                      || m_tdata[1:0] == mpmc_pkg::ST_PHASE))
        else $error("undefined status code on output");

    a_error_no_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != mpmc_pkg::ST_OK) |-> (m_tdata[49:2] == '0))
        else $error("flagged item reports match counts");
`endif

endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for multi_pattern_match_counter: patterns, link builds, texts, clears.
// Keeps its own model of the trie and automaton and checks every output beat; needs mpmc_pkg.
`timescale 1ns / 1ps
module tb_top;

    localparam int WATCHDOG_LIMIT = 250000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct {
        mpmc_pkg::func_t func;
        logic [4:0]      sym;
        logic            last;
    } item_t;

    typedef struct {
        mpmc_pkg::status_t st;
        logic [15:0]       here;
        logic [31:0]       total;
        logic [9:0]        node;
        logic              last;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;

    multi_pattern_match_counter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    item_t      pending_items[$];
    outcome_t   expected_beats[$];
    logic [4:0] pattern_pool[$];
    int         fail_count = 0;
    int         idle_cycles = 0;
    int         send_gap = 0;
    int         stall_left = 0;
    logic       in_taken = 1'b0;
    logic       burst_mode = 1'b0;

    // Shadow copy of the automaton.
    logic        gt_ok[mpmc_pkg::GT_DEPTH];
    logic [9:0]  gt_nd[mpmc_pkg::GT_DEPTH];
    logic [9:0]  sfx_link[mpmc_pkg::MAX_NODES];
    logic [15:0] hit_count[mpmc_pkg::MAX_NODES];
    logic [9:0]  bfs_order[mpmc_pkg::MAX_NODES];
    int          nodes_used;
    logic [9:0]  ins_node;
    logic        pat_dropped;
    logic        links_done;
    logic [9:0]  txt_node;
    logic [31:0] txt_total;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_automaton();
        for (int i = 0; i < mpmc_pkg::GT_DEPTH; i++)
        begin
            gt_ok[i] = 1'b0;
            gt_nd[i] = '0;
        end
        for (int i = 0; i < mpmc_pkg::MAX_NODES; i++)
        begin
            sfx_link[i]  = '0;
            hit_count[i] = '0;
            bfs_order[i] = '0;
        end
        nodes_used  = 1;
        ins_node    = '0;
        pat_dropped = 1'b0;
        links_done  = 1'b0;
        txt_node    = '0;
        txt_total   = '0;
    endfunction

    function automatic logic [15:0] add_count(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void build_suffix_links();
        int head;
        int tail;
        int u;
        int lu;
        int v;
        logic [9:0] via;
        head = 0;
        tail = 0;
        for (int i = 0; i < mpmc_pkg::ALPHABET; i++)
        begin
            if (gt_ok[i])
            begin
                sfx_link[gt_nd[i]] = '0;
                bfs_order[tail] = gt_nd[i];
                tail++;
            end
            else
            begin
                gt_ok[i] = 1'b1;
                gt_nd[i] = '0;
            end
        end
        while (head < tail)
        begin
            u = bfs_order[head];
            head++;
            lu = sfx_link[u];
            for (int i = 0; i < mpmc_pkg::ALPHABET; i++)
            begin
                via = gt_nd[lu * mpmc_pkg::ALPHABET + i];
                if (gt_ok[u * mpmc_pkg::ALPHABET + i])
                begin
                    v = gt_nd[u * mpmc_pkg::ALPHABET + i];
                    sfx_link[v]  = via;
                    hit_count[v] = add_count(hit_count[v], hit_count[via]);
                    if (tail < mpmc_pkg::MAX_NODES)
                    begin
                        bfs_order[tail] = v;
                        tail++;
                    end
                end
                else
                begin
                    gt_ok[u * mpmc_pkg::ALPHABET + i] = 1'b1;
                    gt_nd[u * mpmc_pkg::ALPHABET + i] = via;
                end
            end
        end
    endfunction

    function automatic outcome_t step_automaton(input item_t it);
        outcome_t   r;
        int         idx;
        logic [32:0] sum;
        r.st    = mpmc_pkg::ST_OK;
        r.here  = '0;
        r.total = '0;
        r.node  = '0;
        r.last  = it.last;
        case (it.func)
            mpmc_pkg::FUNC_PATTERN:
            begin
                if (links_done || it.sym >= mpmc_pkg::ALPHABET)
                begin
                    r.st = mpmc_pkg::ST_PHASE;
                end
                else
                begin
                    if (!pat_dropped)
                    begin
                        idx = ins_node * mpmc_pkg::ALPHABET + it.sym;
                        if (gt_ok[idx])
                        begin
                            ins_node = gt_nd[idx];
                        end
                        else if (nodes_used >= mpmc_pkg::MAX_NODES)
                        begin
                            pat_dropped = 1'b1;
                        end
                        else
                        begin
                            gt_ok[idx] = 1'b1;
                            gt_nd[idx] = 10'(nodes_used);
                            ins_node   = 10'(nodes_used);
                            nodes_used++;
                        end
                    end
                    if (pat_dropped)
                        r.st = mpmc_pkg::ST_FULL;
                    else if (it.last)
                        hit_count[ins_node] = add_count(hit_count[ins_node], 16'd1);
                    if (it.last)
                    begin
                        ins_node    = '0;
                        pat_dropped = 1'b0;
                    end
                end
                r.node = ins_node;
            end
            mpmc_pkg::FUNC_BUILD:
            begin
                if (links_done)
                begin
                    r.st = mpmc_pkg::ST_PHASE;
                end
                else
                begin
                    build_suffix_links();
                    links_done  = 1'b1;
                    ins_node    = '0;
                    pat_dropped = 1'b0;
                end
            end
            mpmc_pkg::FUNC_TEXT:
            begin
                if (!links_done)
                begin
                    r.st   = mpmc_pkg::ST_PHASE;
                    r.node = txt_node;
                end
                else
                begin
                    if (it.sym < mpmc_pkg::ALPHABET)
                        txt_node = gt_nd[txt_node * mpmc_pkg::ALPHABET + it.sym];
                    else
                        txt_node = '0;
                    r.here = hit_count[txt_node];
                    sum = {1'b0, txt_total} + 33'(r.here);
                    txt_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    r.total = txt_total;
                    r.node  = txt_node;
                    if (it.last)
                    begin
                        txt_node  = '0;
                        txt_total = '0;
                    end
                end
            end
            default:
            begin
                clear_automaton();
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Drive side: a beat holds until it is taken, then a random gap may follow.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            burst_mode <= ~burst_mode;
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item_t it;
                it = pending_items.pop_front();
                s_tdata  <= {1'b0, it.sym, it.func};
                s_tlast  <= it.last;
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Sample side: predict on every accepted input beat, compare every output beat.
    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                item_t it;
                it.func = mpmc_pkg::func_t'(s_tdata[1:0]);
                it.sym  = s_tdata[6:2];
                it.last = s_tlast;
                expected_beats.insert(expected_beats.size(), step_automaton(it));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("output beat with no expected result");
                    fail_count++;
                end
                else
                begin
                    outcome_t e;
                    e = expected_beats.pop_front();
                    check_field("status", 32'(e.st), 32'(m_tdata[1:0]));
                    check_field("matches_here", 32'(e.here), 32'(m_tdata[17:2]));
                    check_field("running_total", e.total, m_tdata[49:18]);
                    check_field("node_now", 32'(e.node), 32'(m_tdata[59:50]));
                    check_field("end_of_run", 32'(e.last), 32'(m_tlast));
                    check_field("tdata pad", 32'd0, 32'(m_tdata[63:60]));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("multi_pattern_match_counter: mismatch");
                $finish;
            end
        end
    end

    task automatic put(input mpmc_pkg::func_t f, input int sym, input logic last);
        item_t it;
        it.func = f;
        it.sym  = 5'(sym);
        it.last = last;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic add_pattern(input int len, input int max_sym);
        int s;
        for (int i = 0; i < len; i++)
        begin
            s = $urandom_range(0, max_sym);
            pattern_pool.insert(pattern_pool.size(), 5'(s));
            put(mpmc_pkg::FUNC_PATTERN, s, i == len - 1);
        end
    endtask

    // Texts are built mostly from stretches of known patterns so that matches occur.
    task automatic add_text(input int len, input int max_sym);
        int pos;
        int s;
        pos = 0;
        for (int i = 0; i < len; i++)
        begin
            if (pattern_pool.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 4) == 0 || pos >= pattern_pool.size())
                    pos = $urandom_range(0, pattern_pool.size() - 1);
                s = pattern_pool[pos];
                pos++;
            end
            else if ($urandom_range(0, 40) == 0)
            begin
                s = $urandom_range(mpmc_pkg::ALPHABET, 31);
            end
            else
            begin
                s = $urandom_range(0, max_sym);
            end
            put(mpmc_pkg::FUNC_TEXT, s, i == len - 1);
        end
    endtask

    task automatic random_phase(input int n_pat, input int max_len, input int max_sym,
                                input int text_items);
        int sent;
        int len;
        pattern_pool.delete();
        put(mpmc_pkg::FUNC_CLEAR, $urandom_range(0, 31), $urandom_range(0, 1));
        if ($urandom_range(0, 1))
            put(mpmc_pkg::FUNC_TEXT, $urandom_range(0, 31), $urandom_range(0, 1));
        for (int p = 0; p < n_pat; p++)
        begin
            add_pattern($urandom_range(1, max_len), max_sym);
            if ($urandom_range(0, 9) == 0)
                put(mpmc_pkg::FUNC_PATTERN, $urandom_range(mpmc_pkg::ALPHABET, 31),
                    $urandom_range(0, 1));
        end
        put(mpmc_pkg::FUNC_BUILD, $urandom_range(0, 31), $urandom_range(0, 1));
        sent = 0;
        while (sent < text_items)
        begin
            len = $urandom_range(1, 30);
            add_text(len, max_sym);
            sent += len;
            if ($urandom_range(0, 12) == 0)
                put($urandom_range(0, 1) ? mpmc_pkg::FUNC_PATTERN : mpmc_pkg::FUNC_BUILD,
                    $urandom_range(0, 31), $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        int total_syms;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        clear_automaton();

        // Directed: wrong-phase items, alphabet extremes, build mid-pattern, build twice.
        put(mpmc_pkg::FUNC_TEXT, 0, 1'b1);
        put(mpmc_pkg::FUNC_PATTERN, 0, 1'b0);
        put(mpmc_pkg::FUNC_PATTERN, 25, 1'b1);
        put(mpmc_pkg::FUNC_PATTERN, 31, 1'b1);
        put(mpmc_pkg::FUNC_PATTERN, 26, 1'b0);
        put(mpmc_pkg::FUNC_PATTERN, 25, 1'b1);
        put(mpmc_pkg::FUNC_PATTERN, 25, 1'b1);
        put(mpmc_pkg::FUNC_PATTERN, 0, 1'b0);
        put(mpmc_pkg::FUNC_PATTERN, 25, 1'b1);
        put(mpmc_pkg::FUNC_PATTERN, 3, 1'b0);
        put(mpmc_pkg::FUNC_PATTERN, 4, 1'b0);
        put(mpmc_pkg::FUNC_BUILD, 0, 1'b0);
        put(mpmc_pkg::FUNC_BUILD, 31, 1'b1);
        put(mpmc_pkg::FUNC_PATTERN, 1, 1'b1);
        put(mpmc_pkg::FUNC_TEXT, 0, 1'b0);
        put(mpmc_pkg::FUNC_TEXT, 25, 1'b0);
        put(mpmc_pkg::FUNC_TEXT, 25, 1'b0);
        put(mpmc_pkg::FUNC_TEXT, 31, 1'b0);
        put(mpmc_pkg::FUNC_TEXT, 0, 1'b0);
        put(mpmc_pkg::FUNC_TEXT, 25, 1'b1);
        put(mpmc_pkg::FUNC_TEXT, 26, 1'b1);
        put(mpmc_pkg::FUNC_TEXT, 3, 1'b1);

        // Fill the trie past its capacity with long random patterns.
        pattern_pool.delete();
        put(mpmc_pkg::FUNC_CLEAR, 0, 1'b0);
        total_syms = 0;
        while (total_syms < 1080)
        begin
            int len;
            len = $urandom_range(10, 40);
            add_pattern(len, mpmc_pkg::ALPHABET - 1);
            total_syms += len;
        end
        put(mpmc_pkg::FUNC_PATTERN, 7, 1'b1);
        put(mpmc_pkg::FUNC_BUILD, 0, 1'b0);
        add_text(120, mpmc_pkg::ALPHABET - 1);

        random_phase(14, 5, 3, 280);
        random_phase(10, 8, 1, 280);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_items.size() == 0);
        @(posedge clk);
        wait (!s_tvalid && expected_beats.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_beats.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("multi_pattern_match_counter: match");
        else
            $display("multi_pattern_match_counter: mismatch");
        $finish;
    end
endmodule

### multi_pattern_match_counter.f
hw/rtl/mpmc_pkg.sv
hw/rtl/mpmc_ctrl.sv
hw/rtl/mpmc_datapath.sv
hw/rtl/multi_pattern_match_counter.sv
test/tb_top.sv
